// File: rtl/cse_pkg.sv
`default_nettype none
package cse_pkg;

   localparam int COORD_BITS   = 12;
   localparam int FRAC_BITS    = 8;
   localparam int VTX_BITS     = COORD_BITS + FRAC_BITS;
   localparam int MUL_BITS     = 2 * VTX_BITS;
   localparam int DSQ_BITS     = MUL_BITS + 1;
   localparam int SQRT_IN_BITS = 62;
   localparam int EXTRA_BITS   = (SQRT_IN_BITS - DSQ_BITS) / 2;
   localparam int WIDE_BITS    = 64;
   localparam int QUOT_BITS    = 17;
   localparam int DIR_BITS     = 16;
   localparam int DIR_ONE      = 16384;
   localparam int DIST_BITS    = 21;
   localparam int LEN_BITS     = 32;
   localparam int NEAR_SHIFT   = 28;
   localparam int DIR_SHIFT    = 14 + EXTRA_BITS;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = VTX_BITS;
   localparam logic [CSR_INDEX_BITS-1:0] REG_VERTEX_X = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_VERTEX_Y = 1'b1;

   typedef struct packed {
      logic [COORD_BITS-1:0] hit_x;
      logic [COORD_BITS-1:0] hit_y;
      logic                  last_hit;
   } cse_req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]      start_x;
      logic [COORD_BITS-1:0]      start_y;
      logic [COORD_BITS-1:0]      end_x;
      logic [COORD_BITS-1:0]      end_y;
      logic [DIST_BITS-1:0]       start_distance;
      logic signed [DIR_BITS-1:0] dir_x;
      logic signed [DIR_BITS-1:0] dir_y;
      logic                       zero_length;
   } cse_rsp_type;

   typedef struct packed {
      logic start;
      logic is_sqrt;
   } cse_eng_cmd_type;

   function automatic logic [VTX_BITS-1:0] abs_diff(input logic [VTX_BITS-1:0] a,
                                                    input logic [VTX_BITS-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   // Clamps a rounded quotient to unit length and applies the sign.
   function automatic logic [DIR_BITS-1:0] make_dir(input logic [WIDE_BITS-1:0] q,
                                                    input logic neg);
      logic [DIR_BITS-1:0] m;
      m = (q > WIDE_BITS'(DIR_ONE)) ? DIR_BITS'(DIR_ONE) : q[DIR_BITS-1:0];
      return neg ? (~m + 1'b1) : m;
   endfunction

endpackage
`default_nettype wire

// File: rtl/cse_engine.sv
`default_nettype none
module cse_engine import cse_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cse_eng_cmd_type      cmd,
   input  wire logic [WIDE_BITS-1:0] arg_a,
   input  wire logic [WIDE_BITS-1:0] arg_b,
   output logic                      done,
   output logic [WIDE_BITS-1:0]      result
);

   localparam int SQRT_STEPS = SQRT_IN_BITS / 2;
   localparam int CNT_BITS   = $clog2(SQRT_STEPS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 sqrt_ff, sqrt_in;
   logic                 ovf_ff, ovf_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [WIDE_BITS-1:0] rem_ff, rem_in;
   logic [WIDE_BITS-1:0] acc_ff, acc_in;
   logic [WIDE_BITS-1:0] bit_ff, bit_in;
   logic [WIDE_BITS-1:0] opb;
   logic [WIDE_BITS-1:0] diff;
   logic                 ge;

   // The single compare-subtract shared by square root and division.
   // In the root loop the trial bit never overlaps the partial root.
   assign opb  = sqrt_ff ? (acc_ff | bit_ff) : bit_ff;
   assign ge   = rem_ff >= opb;
   assign diff = rem_ff - opb;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      sqrt_in = sqrt_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      bit_in  = bit_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         sqrt_in = cmd.is_sqrt;
         rem_in  = arg_a;
         acc_in  = '0;
         if (cmd.is_sqrt) begin
            bit_in = WIDE_BITS'(1) << (SQRT_IN_BITS - 2);
            cnt_in = CNT_BITS'(SQRT_STEPS);
            ovf_in = 1'b0;
         end else begin
            bit_in = arg_b << (QUOT_BITS - 1);
            cnt_in = CNT_BITS'(QUOT_BITS);
            ovf_in = (arg_a >> QUOT_BITS) >= arg_b;
         end
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = diff;
         end
         if (sqrt_ff) begin
            acc_in = (acc_ff >> 1) | (ge ? bit_ff : '0);
            bit_in = bit_ff >> 2;
         end else begin
            acc_in = {acc_ff[WIDE_BITS-2:0], ge};
            bit_in = bit_ff >> 1;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sqrt_ff <= sqrt_in;
      ovf_ff  <= ovf_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      acc_ff  <= acc_in;
      bit_ff  <= bit_in;
   end

   assign done   = done_ff;
   assign result = ovf_ff ? '1 : acc_ff;

endmodule
`default_nettype wire

// File: rtl/cluster_start_end_direction_top.sv
`default_nettype none
// Finds the start and end hits of a pixel cluster relative to a configured vertex and
// returns the start point, end point, start-to-vertex distance and a Q1.14 unit direction
// once the hit flagged as last has been taken. Each hit request occupies the block while
// the one registered squaring multiplier is used twice for it. For a last hit, one
// compare-subtract unit computes up to two 31-step square roots (distance and normalising
// length) and up to two 17-step divisions, one bit per cycle. The response waits in its
// output registers until taken; stall is high meanwhile.
module cluster_start_end_direction_top import cse_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire cse_req_type               req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output cse_rsp_type                    rsp_data,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   typedef enum logic [19:0] {
      S_IDLE  = 20'h00001, S_HSQX  = 20'h00002, S_HSQY  = 20'h00004, S_HUPD  = 20'h00008,
      S_SOFF  = 20'h00010, S_SSQX  = 20'h00020, S_SSQY  = 20'h00040, S_SSUM  = 20'h00080,
      S_DGO   = 20'h00100, S_DWAIT = 20'h00200, S_LSQX  = 20'h00400, S_LSQY  = 20'h00800,
      S_LSUM  = 20'h01000, S_LGO   = 20'h02000, S_LWAIT = 20'h04000, S_XGO   = 20'h08000,
      S_XWAIT = 20'h10000, S_YGO   = 20'h20000, S_YWAIT = 20'h40000, S_OUT   = 20'h80000
   } state_type;

   localparam int PT_BITS = 2 * COORD_BITS;

   state_type              state_ff, state_in;
   logic [VTX_BITS-1:0]    vx_ff, vy_ff;
   logic                   first_ff;
   logic [DSQ_BITS-1:0]    near_dsq_ff, far_dsq_ff;
   logic [PT_BITS-1:0]     near_pt_ff, far_pt_ff;
   logic [VTX_BITS-1:0]    dmx_ff, dmy_ff;
   logic                   last_ff;
   logic [VTX_BITS-1:0]    smx_ff, smy_ff;
   logic                   ssx_ff, ssy_ff;
   logic [COORD_BITS-1:0]  lmx_ff, lmy_ff;
   logic                   lsx_ff, lsy_ff;
   logic [MUL_BITS-1:0]    mul_ff, acc_ff;
   logic [DSQ_BITS-1:0]    sum_ff;
   logic                   near_ff;
   logic [DIST_BITS-1:0]   dist_ff;
   logic [LEN_BITS-1:0]    len_ff;
   logic [DIR_BITS-1:0]    dirx_ff, diry_ff;
   logic                   zero_ff;

   // The point of the hit being compared, packed y above x.
   logic [PT_BITS-1:0]     hit_pt_q;
   logic [COORD_BITS-1:0]  hx_ff, hy_ff;

   logic [VTX_BITS-1:0]    mul_op;
   logic [DSQ_BITS-1:0]    sq_sum;
   logic [COORD_BITS-1:0]  nx, ny, fx, fy;
   logic [VTX_BITS-1:0]    nx_fx, ny_fx;
   cse_eng_cmd_type        eng_cmd;
   logic [WIDE_BITS-1:0]   eng_a, eng_b;
   logic                   eng_done;
   logic [WIDE_BITS-1:0]   eng_res;
   logic [WIDE_BITS-1:0]   num_x, num_y, len_w;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   assign hit_pt_q = {hy_ff, hx_ff};
   assign sq_sum = DSQ_BITS'(acc_ff) + DSQ_BITS'(mul_ff);
   assign nx     = near_pt_ff[COORD_BITS-1:0];
   assign ny     = near_pt_ff[PT_BITS-1:COORD_BITS];
   assign fx     = far_pt_ff[COORD_BITS-1:0];
   assign fy     = far_pt_ff[PT_BITS-1:COORD_BITS];
   assign nx_fx  = {nx, FRAC_BITS'(0)};
   assign ny_fx  = {ny, FRAC_BITS'(0)};

   // Dividend and divisor of the rounded quotient: (2*mag + len) / (2*len).
   assign len_w = WIDE_BITS'(len_ff);
   assign num_x = near_ff ? ((WIDE_BITS'(lmx_ff) << (NEAR_SHIFT + 1)) + len_w)
                          : ((WIDE_BITS'(smx_ff) << (DIR_SHIFT + 1)) + len_w);
   assign num_y = near_ff ? ((WIDE_BITS'(lmy_ff) << (NEAR_SHIFT + 1)) + len_w)
                          : ((WIDE_BITS'(smy_ff) << (DIR_SHIFT + 1)) + len_w);

   always_comb begin
      case (state_ff)
         S_HSQX:  mul_op = dmx_ff;
         S_HSQY:  mul_op = dmy_ff;
         S_SSQX:  mul_op = smx_ff;
         S_SSQY:  mul_op = smy_ff;
         S_LSQX:  mul_op = VTX_BITS'(lmx_ff);
         S_LSQY:  mul_op = VTX_BITS'(lmy_ff);
         default: mul_op = '0;
      endcase
   end

   always_comb begin
      eng_cmd = '0;
      eng_a   = '0;
      eng_b   = '0;
      case (state_ff)
         S_DGO: begin
            eng_cmd = '{start: 1'b1, is_sqrt: 1'b1};
            eng_a   = WIDE_BITS'(sum_ff);
         end
         S_LGO: begin
            eng_cmd = '{start: 1'b1, is_sqrt: 1'b1};
            eng_a   = near_ff ? (WIDE_BITS'(sum_ff) << NEAR_SHIFT)
                              : (WIDE_BITS'(sum_ff) << (2 * EXTRA_BITS));
         end
         S_XGO: begin
            eng_cmd = '{start: 1'b1, is_sqrt: 1'b0};
            eng_a   = num_x;
            eng_b   = len_w << 1;
         end
         S_YGO: begin
            eng_cmd = '{start: 1'b1, is_sqrt: 1'b0};
            eng_a   = num_y;
            eng_b   = len_w << 1;
         end
         default: begin
            eng_cmd = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_HSQX;
         S_HSQX:  state_in = S_HSQY;
         S_HSQY:  state_in = S_HUPD;
         S_HUPD:  state_in = last_ff ? S_SOFF : S_IDLE;
         S_SOFF:  state_in = S_SSQX;
         S_SSQX:  state_in = S_SSQY;
         S_SSQY:  state_in = S_SSUM;
         S_SSUM:  state_in = S_DGO;
         S_DGO:   state_in = S_DWAIT;
         S_DWAIT: if (eng_done) state_in = near_ff ? S_LSQX : S_LGO;
         S_LSQX:  state_in = S_LSQY;
         S_LSQY:  state_in = S_LSUM;
         S_LSUM:  state_in = (sq_sum == '0) ? S_OUT : S_LGO;
         S_LGO:   state_in = S_LWAIT;
         S_LWAIT: if (eng_done) state_in = S_XGO;
         S_XGO:   state_in = S_XWAIT;
         S_XWAIT: if (eng_done) state_in = S_YGO;
         S_YGO:   state_in = S_YWAIT;
         S_YWAIT: if (eng_done) state_in = S_OUT;
         S_OUT:   if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         vx_ff       <= '0;
         vy_ff       <= '0;
         first_ff    <= 1'b1;
         near_dsq_ff <= '0;
         far_dsq_ff  <= '0;
         near_pt_ff  <= '0;
         far_pt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               REG_VERTEX_X: vx_ff <= csr_wdata;
               REG_VERTEX_Y: vy_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == S_HUPD) begin
            first_ff <= last_ff;
            if (first_ff || sq_sum < near_dsq_ff) begin
               near_dsq_ff <= sq_sum;
               near_pt_ff  <= hit_pt_q;
            end
            if (first_ff || sq_sum > far_dsq_ff) begin
               far_dsq_ff <= sq_sum;
               far_pt_ff  <= hit_pt_q;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= MUL_BITS'(mul_op) * MUL_BITS'(mul_op);
      acc_ff <= mul_ff;
      if (state_ff == S_IDLE && req_valid) begin
         hx_ff   <= req_data.hit_x;
         hy_ff   <= req_data.hit_y;
         last_ff <= req_data.last_hit;
         dmx_ff  <= abs_diff({req_data.hit_x, FRAC_BITS'(0)}, vx_ff);
         dmy_ff  <= abs_diff({req_data.hit_y, FRAC_BITS'(0)}, vy_ff);
      end
      case (state_ff)
         S_SOFF: begin
            smx_ff  <= abs_diff(nx_fx, vx_ff);
            smy_ff  <= abs_diff(ny_fx, vy_ff);
            ssx_ff  <= nx_fx < vx_ff;
            ssy_ff  <= ny_fx < vy_ff;
            lmx_ff  <= (fx >= nx) ? (fx - nx) : (nx - fx);
            lmy_ff  <= (fy >= ny) ? (fy - ny) : (ny - fy);
            lsx_ff  <= fx < nx;
            lsy_ff  <= fy < ny;
            zero_ff <= 1'b0;
            dirx_ff <= '0;
            diry_ff <= '0;
         end
         S_SSUM: begin
            sum_ff  <= sq_sum;
            near_ff <= sq_sum < (DSQ_BITS'(1) << (2 * FRAC_BITS));
         end
         S_DWAIT: begin
            if (eng_done) begin
               dist_ff <= (eng_res > WIDE_BITS'({DIST_BITS{1'b1}})) ? '1
                                                                   : eng_res[DIST_BITS-1:0];
            end
         end
         S_LSUM: begin
            sum_ff  <= sq_sum;
            zero_ff <= (sq_sum == '0);
         end
         S_LWAIT: begin
            if (eng_done) len_ff <= eng_res[LEN_BITS-1:0];
         end
         S_XWAIT: begin
            if (eng_done) dirx_ff <= make_dir(eng_res, near_ff ? lsx_ff : ssx_ff);
         end
         S_YWAIT: begin
            if (eng_done) diry_ff <= make_dir(eng_res, near_ff ? lsy_ff : ssy_ff);
         end
         default: ;
      endcase
   end

   cse_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cmd    (eng_cmd),
      .arg_a  (eng_a),
      .arg_b  (eng_b),
      .done   (eng_done),
      .result (eng_res)
   );

   assign rsp_data.start_x        = nx;
   assign rsp_data.start_y        = ny;
   assign rsp_data.end_x          = fx;
   assign rsp_data.end_y          = fy;
   assign rsp_data.start_distance = dist_ff;
   assign rsp_data.dir_x          = dirx_ff;
   assign rsp_data.dir_y          = diry_ff;
   assign rsp_data.zero_length    = zero_ff;

endmodule
`default_nettype wire
